// File: rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Types and constants shared by the servo cart command supervisor modules.
// ----------------------------------------------------------------------------
package scs_pkg;

   // request payload, one control tick
   typedef struct packed {
      logic signed [31:0] motor_position;
      logic signed [31:0] motor_velocity;
      logic               new_command;
      logic signed [7:0]  command_code;
      logic signed [31:0] command_value;
   } req_type;

   // result payload
   typedef struct packed {
      logic [1:0]         drive_kind;
      logic signed [31:0] drive_value;
      logic [2:0]         operating_mode;
      logic               finished;
   } rsp_type;

   // register indexes of the csr port
   localparam logic [2:0] CSR_TIMEOUT       = 3'd0;
   localparam logic [2:0] CSR_RECENTER_GAIN = 3'd1;
   localparam logic [2:0] CSR_IDLE_GAIN     = 3'd2;
   localparam logic [2:0] CSR_POS_THRESH    = 3'd3;
   localparam logic [2:0] CSR_VEL_THRESH    = 3'd4;
   localparam logic [2:0] CSR_IDLE_THRESH   = 3'd5;

   // register reset values
   localparam logic [15:0] TIMEOUT_RESET       = 16'd100;
   localparam logic [15:0] GAIN_RESET          = 16'd3840;
   localparam logic [30:0] POS_THRESH_RESET    = 31'd164;
   localparam logic [30:0] VEL_THRESH_RESET    = 31'd1638;
   localparam logic [30:0] IDLE_THRESH_RESET   = 31'd1311;

   // drive kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_ACCEL = 2'd1;
   localparam logic [1:0] KIND_VEL   = 2'd2;

   // operating mode codes as reported
   localparam logic [2:0] MODE_CODE_EXECUTE     = 3'd0;
   localparam logic [2:0] MODE_CODE_RECENTER    = 3'd1;
   localparam logic [2:0] MODE_CODE_IDLE        = 3'd2;
   localparam logic [2:0] MODE_CODE_TERMINATING = 3'd3;
   localparam logic [2:0] MODE_CODE_STOPPED     = 3'd4;

   // command codes
   localparam logic signed [7:0] CMD_RECENTER = 8'sd0;
   localparam logic signed [7:0] CMD_ACCEL    = 8'sd1;
   localparam logic signed [7:0] CMD_VEL      = 8'sd2;

   // supervisor mode, one-hot
   typedef enum logic [4:0] {
      MODE_EXECUTE     = 5'b00001,
      MODE_RECENTER    = 5'b00010,
      MODE_IDLE        = 5'b00100,
      MODE_TERMINATING = 5'b01000,
      MODE_STOPPED     = 5'b10000
   } mode_type;

   // how the back end forms the drive value
   typedef enum logic [1:0] {
      OP_DIRECT   = 2'd0,
      OP_RECENTER = 2'd1,
      OP_IDLE     = 2'd2
   } op_type;

   // classified request passed from front to back
   typedef struct packed {
      op_type             op;
      logic [1:0]         drive_kind;
      logic signed [32:0] operand;
      logic [2:0]         mode_code;
   } entry_type;

   // settings seen by the front end
   typedef struct packed {
      logic [15:0] timeout;
      logic [30:0] pos_thresh;
      logic [30:0] vel_thresh;
      logic [30:0] idle_thresh;
   } front_cfg_type;

   // settings seen by the back end
   typedef struct packed {
      logic [15:0] recenter_gain;
      logic [15:0] idle_gain;
   } back_cfg_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_EXECUTE:     c = MODE_CODE_EXECUTE;
         MODE_RECENTER:    c = MODE_CODE_RECENTER;
         MODE_IDLE:        c = MODE_CODE_IDLE;
         MODE_TERMINATING: c = MODE_CODE_TERMINATING;
         MODE_STOPPED:     c = MODE_CODE_STOPPED;
         default:          c = MODE_CODE_STOPPED;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] m;
      m = v[31] ? (~v + 32'd1) : v;
      return m;
   endfunction

endpackage

// File: rtl/servo_cart_command_supervisor.sv
// ----------------------------------------------------------------------------
// servo_cart_command_supervisor
// Per-tick cart supervisor: command watchdog, mode sequencing and PD braking.
// ----------------------------------------------------------------------------
//  channel   ports                                 direction
//  request   req_push, req_full, req_data          in  (queue write side)
//  response  rsp_pop, rsp_empty, rsp_data          out (queue read side)
//  csr       csr_we, csr_addr, csr_wdata           in  (write only)
//
//  One request per cycle while req_full is low; the front decides mode in the
//  accept cycle. Responses pass the queue, then the multiply and round stages.
//  Reset (synchronous) restores mode, watchdog, stored command and registers.
//  A stalled response backs up the two back stages, then the queue, then
//  req_full rises; QUEUE_DEPTH sets how many requests the front runs ahead.
// ----------------------------------------------------------------------------
module servo_cart_command_supervisor import scs_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [30:0] csr_wdata
);

   logic [15:0]   timeout_ff;
   logic [15:0]   recenter_gain_ff;
   logic [15:0]   idle_gain_ff;
   logic [30:0]   pos_thresh_ff;
   logic [30:0]   vel_thresh_ff;
   logic [30:0]   idle_thresh_ff;
   front_cfg_type front_cfg;
   back_cfg_type  back_cfg;
   logic          entry_push, entry_pop, entry_valid;
   entry_type     entry_in, entry_head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff       <= TIMEOUT_RESET;
         recenter_gain_ff <= GAIN_RESET;
         idle_gain_ff     <= GAIN_RESET;
         pos_thresh_ff    <= POS_THRESH_RESET;
         vel_thresh_ff    <= VEL_THRESH_RESET;
         idle_thresh_ff   <= IDLE_THRESH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TIMEOUT:       timeout_ff       <= csr_wdata[15:0];
            CSR_RECENTER_GAIN: recenter_gain_ff <= csr_wdata[15:0];
            CSR_IDLE_GAIN:     idle_gain_ff     <= csr_wdata[15:0];
            CSR_POS_THRESH:    pos_thresh_ff    <= csr_wdata;
            CSR_VEL_THRESH:    vel_thresh_ff    <= csr_wdata;
            CSR_IDLE_THRESH:   idle_thresh_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign front_cfg = '{timeout: timeout_ff, pos_thresh: pos_thresh_ff,
                        vel_thresh: vel_thresh_ff, idle_thresh: idle_thresh_ff};
   assign back_cfg  = '{recenter_gain: recenter_gain_ff, idle_gain: idle_gain_ff};

   // front: watchdog and mode sequencing
   scs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .cfg        (front_cfg),
      .entry_push (entry_push),
      .entry      (entry_in)
   );

   // queue between front and back
   scs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_data (entry_in),
      .full      (req_full),
      .pop       (entry_pop),
      .valid     (entry_valid),
      .head      (entry_head)
   );

   // back: drive arithmetic and response register
   scs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (back_cfg),
      .entry_valid (entry_valid),
      .entry       (entry_head),
      .entry_pop   (entry_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

// File: rtl/scs_front.sv
// ----------------------------------------------------------------------------
// scs_front
// Watchdog, command store and mode sequencer; classifies each request.
// ----------------------------------------------------------------------------
module scs_front import scs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  req_type       req_data,
   input  logic          queue_full,
   input  front_cfg_type cfg,
   output logic          entry_push,
   output entry_type     entry
);

   mode_type          mode_ff, mode_in;
   logic [15:0]       ticks_ff, ticks_in;
   logic              first_ff;
   logic signed [7:0] code_ff, code_in;
   logic [31:0]       value_ff, value_in;
   mode_type          mode_wd;
   logic              near_center;
   logic              idle_stopped;

   assign entry_push = req_push && !queue_full;

   // command store and watchdog count
   always_comb begin
      if (req_data.new_command) begin
         code_in  = req_data.command_code;
         value_in = req_data.command_value;
         ticks_in = '0;
      end else begin
         code_in  = code_ff;
         value_in = value_ff;
         ticks_in = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
      end
   end

   // distance checks
   assign near_center  = (mag32(req_data.motor_velocity) < {1'b0, cfg.vel_thresh}) &&
                         (mag32(req_data.motor_position) < {1'b0, cfg.pos_thresh});
   assign idle_stopped = mag32(req_data.motor_velocity) < {1'b0, cfg.idle_thresh};

   // watchdog mode change, execute and idle only
   always_comb begin
      mode_wd = mode_ff;
      if (mode_ff == MODE_EXECUTE || mode_ff == MODE_IDLE) begin
         if (ticks_in > cfg.timeout && mode_ff != MODE_IDLE && !first_ff)
            mode_wd = MODE_IDLE;
         if (ticks_in < cfg.timeout)
            mode_wd = MODE_EXECUTE;
      end
   end

   // classify request
   always_comb begin
      mode_in          = mode_wd;
      entry.op         = OP_DIRECT;
      entry.drive_kind = KIND_NONE;
      entry.operand    = '0;
      case (mode_wd)
         MODE_EXECUTE: begin
            case (code_in)
               CMD_RECENTER: mode_in = MODE_RECENTER;
               CMD_ACCEL: begin
                  entry.drive_kind = KIND_ACCEL;
                  entry.operand    = {value_in[31], value_in};
               end
               CMD_VEL: begin
                  entry.drive_kind = KIND_VEL;
                  entry.operand    = {value_in[31], value_in};
               end
               default: mode_in = MODE_TERMINATING;
            endcase
         end
         MODE_RECENTER, MODE_TERMINATING: begin
            if (near_center) begin
               entry.drive_kind = KIND_VEL;
               mode_in = (mode_wd == MODE_RECENTER) ? MODE_IDLE : MODE_STOPPED;
            end else begin
               entry.drive_kind = KIND_ACCEL;
               entry.op         = OP_RECENTER;
               entry.operand    = {req_data.motor_position[31], req_data.motor_position} +
                                  {req_data.motor_velocity[31], req_data.motor_velocity};
            end
         end
         MODE_IDLE: begin
            entry.drive_kind = idle_stopped ? KIND_VEL : KIND_ACCEL;
            if (!idle_stopped) begin
               entry.op      = OP_IDLE;
               entry.operand = {req_data.motor_velocity[31], req_data.motor_velocity};
            end
         end
         default: mode_in = MODE_STOPPED;
      endcase
      entry.mode_code = mode_code(mode_in);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_EXECUTE;
         ticks_ff <= '0;
         first_ff <= 1'b1;
         code_ff  <= CMD_ACCEL;
         value_ff <= '0;
      end else if (entry_push) begin
         mode_ff  <= mode_in;
         ticks_ff <= ticks_in;
         first_ff <= 1'b0;
         code_ff  <= code_in;
         value_ff <= value_in;
      end
   end

endmodule

// File: rtl/scs_queue.sv
// ----------------------------------------------------------------------------
// scs_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module scs_queue import scs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // storage
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: rtl/scs_back.sv
// ----------------------------------------------------------------------------
// scs_back
// Drive computation: gain multiply, then round and saturate into the result.
// ----------------------------------------------------------------------------
module scs_back import scs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  back_cfg_type cfg,
   input  logic         entry_valid,
   input  entry_type    entry,
   output logic         entry_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_type      rsp_data
);

   typedef struct packed {
      logic [1:0]         drive_kind;
      logic [2:0]         mode_code;
      logic               direct;
      logic [31:0]        direct_value;
      logic signed [49:0] product;
   } prod_type;

   prod_type           s1_ff, s1_in;
   logic               s1_valid_ff;
   rsp_type            s2_ff, s2_in;
   logic               s2_valid_ff;
   logic               s1_ready, s2_ready;
   logic [15:0]        gain;
   logic signed [50:0] rounded;
   logic [31:0]        quot;
   logic               fits;

   assign s2_ready  = !s2_valid_ff || rsp_pop;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign entry_pop = entry_valid && s1_ready;
   assign rsp_empty = !s2_valid_ff;
   assign rsp_data  = s2_ff;

   // multiply stage
   always_comb begin
      gain               = (entry.op == OP_RECENTER) ? cfg.recenter_gain : cfg.idle_gain;
      s1_in.drive_kind   = entry.drive_kind;
      s1_in.mode_code    = entry.mode_code;
      s1_in.direct       = (entry.op == OP_DIRECT);
      s1_in.direct_value = entry.operand[31:0];
      s1_in.product      = 50'($signed({1'b0, gain}) * entry.operand);
   end

   // negate, round half up, take Q16.16 and saturate
   always_comb begin
      rounded = 51'sd128 - {s1_ff.product[49], s1_ff.product};
      fits    = (rounded[50:39] == '0) || (rounded[50:39] == '1);
      if (fits)
         quot = rounded[39:8];
      else if (rounded[50])
         quot = 32'h8000_0000;
      else
         quot = 32'h7FFF_FFFF;
      s2_in.drive_kind     = s1_ff.drive_kind;
      s2_in.drive_value    = s1_ff.direct ? s1_ff.direct_value : quot;
      s2_in.operating_mode = s1_ff.mode_code;
      s2_in.finished       = (s1_ff.mode_code == MODE_CODE_STOPPED);
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (entry_pop)
         s1_ff <= s1_in;
      if (s1_valid_ff && s2_ready)
         s2_ff <= s2_in;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)
            s1_valid_ff <= entry_valid;
         if (s2_ready)
            s2_valid_ff <= s1_valid_ff;
      end
   end

endmodule

// File: test/scs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_checker
// Watches the request, response and csr channels of the cart supervisor,
// runs its own tick-by-tick model of the supervisor and compares every
// popped response field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module scs_checker import scs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [30:0] csr_wdata,
   output int          failures,
   output int          outstanding
);

   // register copies
   logic [15:0] cfg_timeout;
   logic [15:0] cfg_recenter_gain;
   logic [15:0] cfg_idle_gain;
   logic [30:0] cfg_pos_thresh;
   logic [30:0] cfg_vel_thresh;
   logic [30:0] cfg_idle_thresh;

   // supervisor state as predicted
   logic [2:0]        sup_mode;
   logic [15:0]       quiet_ticks;
   logic              first_tick;
   logic signed [7:0] stored_code;
   logic [31:0]       stored_value;
   logic signed [7:0] latched_code;
   logic [31:0]       latched_value;

   rsp_type predicted_rsp[$];
   rsp_type want;

   // -(gain * sum) in Q16.16, rounded half up, saturated to 32 bits
   function automatic logic [31:0] pd_drive(input logic [15:0] gain, input longint sum);
      longint t;
      t = 64'sd128 - longint'({48'd0, gain}) * sum;
      t = t >>> 8;
      if (t > 64'sd2147483647)
         t = 64'sd2147483647;
      else if (t < -64'sd2147483648)
         t = -64'sd2147483648;
      return t[31:0];
   endfunction

   // magnitude strictly below a threshold
   function automatic logic under_limit(input longint v, input logic [30:0] thr);
      if (v < 0)
         v = -v;
      return v < longint'({33'd0, thr});
   endfunction

   // one control tick of the supervisor
   task automatic step_supervisor(input req_type t);
      rsp_type o;
      longint  pos;
      longint  vel;
      pos = t.motor_position;
      vel = t.motor_velocity;
      o = '0;
      o.drive_kind = KIND_NONE;

      // command arrival and watchdog count
      if (t.new_command) begin
         stored_code  = t.command_code;
         stored_value = t.command_value;
         quiet_ticks  = '0;
      end else if (quiet_ticks != 16'hFFFF) begin
         quiet_ticks = quiet_ticks + 16'd1;
      end

      // watchdog, then latch
      if (sup_mode == MODE_CODE_EXECUTE || sup_mode == MODE_CODE_IDLE) begin
         if (quiet_ticks > cfg_timeout && sup_mode != MODE_CODE_IDLE && !first_tick)
            sup_mode = MODE_CODE_IDLE;
         if (quiet_ticks < cfg_timeout)
            sup_mode = MODE_CODE_EXECUTE;
         latched_code  = stored_code;
         latched_value = stored_value;
      end

      case (sup_mode)
         MODE_CODE_EXECUTE: begin
            case (latched_code)
               CMD_RECENTER: sup_mode = MODE_CODE_RECENTER;
               CMD_ACCEL: begin
                  o.drive_kind  = KIND_ACCEL;
                  o.drive_value = latched_value;
               end
               CMD_VEL: begin
                  o.drive_kind  = KIND_VEL;
                  o.drive_value = latched_value;
               end
               default: sup_mode = MODE_CODE_TERMINATING;
            endcase
         end
         MODE_CODE_RECENTER, MODE_CODE_TERMINATING: begin
            if (under_limit(vel, cfg_vel_thresh) && under_limit(pos, cfg_pos_thresh)) begin
               o.drive_kind = KIND_VEL;
               sup_mode = (sup_mode == MODE_CODE_RECENTER) ? MODE_CODE_IDLE
                                                           : MODE_CODE_STOPPED;
            end else begin
               o.drive_kind  = KIND_ACCEL;
               o.drive_value = pd_drive(cfg_recenter_gain, pos + vel);
            end
         end
         MODE_CODE_IDLE: begin
            if (under_limit(vel, cfg_idle_thresh)) begin
               o.drive_kind = KIND_VEL;
            end else begin
               o.drive_kind  = KIND_ACCEL;
               o.drive_value = pd_drive(cfg_idle_gain, vel);
            end
         end
         default: sup_mode = MODE_CODE_STOPPED;
      endcase

      first_tick = 1'b0;
      o.operating_mode = sup_mode;
      o.finished = (sup_mode == MODE_CODE_STOPPED);
      predicted_rsp.push_back(o);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_timeout       = TIMEOUT_RESET;
         cfg_recenter_gain = GAIN_RESET;
         cfg_idle_gain     = GAIN_RESET;
         cfg_pos_thresh    = POS_THRESH_RESET;
         cfg_vel_thresh    = VEL_THRESH_RESET;
         cfg_idle_thresh   = IDLE_THRESH_RESET;
         sup_mode      = MODE_CODE_EXECUTE;
         quiet_ticks   = '0;
         first_tick    = 1'b1;
         stored_code   = CMD_ACCEL;
         stored_value  = '0;
         latched_code  = CMD_ACCEL;
         latched_value = '0;
         predicted_rsp.delete();
         failures = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               CSR_TIMEOUT:       cfg_timeout       = csr_wdata[15:0];
               CSR_RECENTER_GAIN: cfg_recenter_gain = csr_wdata[15:0];
               CSR_IDLE_GAIN:     cfg_idle_gain     = csr_wdata[15:0];
               CSR_POS_THRESH:    cfg_pos_thresh    = csr_wdata;
               CSR_VEL_THRESH:    cfg_vel_thresh    = csr_wdata;
               CSR_IDLE_THRESH:   cfg_idle_thresh   = csr_wdata;
               default: ;
            endcase
         end

         // accepted request
         if (req_push && !req_full)
            step_supervisor(req_data);

         // accepted response
         if (rsp_pop && !rsp_empty) begin
            if (predicted_rsp.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected response: kind %0d value %0d mode %0d finished %0d",
                           rsp_data.drive_kind, rsp_data.drive_value,
                           rsp_data.operating_mode, rsp_data.finished);
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_data.drive_kind !== want.drive_kind ||
                   rsp_data.drive_value !== want.drive_value ||
                   rsp_data.operating_mode !== want.operating_mode ||
                   rsp_data.finished !== want.finished) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("response mismatch: expected kind %0d value %0d mode %0d %s %0d",
                              want.drive_kind, want.drive_value, want.operating_mode,
                              "finished", want.finished);
                     $display("                   got      kind %0d value %0d mode %0d %s %0d",
                              rsp_data.drive_kind, rsp_data.drive_value,
                              rsp_data.operating_mode, "finished", rsp_data.finished);
                  end
               end
            end
         end
      end
      outstanding <= predicted_rsp.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the servo cart command supervisor. Runs directed
// ticks through every mode, then random ticks under several register
// settings and idle patterns, a long quiet run at the largest timeout and a
// final termination sequence; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
   import scs_pkg::*;

   localparam int LIMIT_CYCLES = 100000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_pop   = 1'b0;
   logic        csr_we    = 1'b0;
   logic [2:0]  csr_addr  = '0;
   logic [30:0] csr_wdata = '0;
   logic        req_full;
   logic        rsp_empty;
   rsp_type     rsp_data;

   int failures;
   int outstanding;
   int send_idle = 22;
   int recv_idle = 72;
   int pos_near  = 400;
   int vel_near  = 3000;
   int cycles    = 0;

   logic signed [7:0] term_code;

   servo_cart_command_supervisor dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   scs_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side stalls
   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= recv_idle);

   function automatic req_type make_tick(input logic [31:0] pos, input logic [31:0] vel,
                                         input logic cmd, input logic [7:0] code,
                                         input logic [31:0] value);
      req_type r;
      r.motor_position = pos;
      r.motor_velocity = vel;
      r.new_command    = cmd;
      r.command_code   = code;
      r.command_value  = value;
      return r;
   endfunction

   // Q16.16 word: near zero, medium, full range or an extreme
   function automatic logic [31:0] rand_word(input int near);
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         return int'($urandom_range(0, 2 * near)) - near;
      else if (pick < 65)
         return int'($urandom_range(0, 1 << 21)) - (1 << 20);
      else if (pick < 90)
         return $urandom;
      case ($urandom_range(3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic req_type rand_tick(input logic any_code, input logic quiet);
      req_type r;
      if ($urandom_range(99) < 30) begin
         r.motor_position = int'($urandom_range(0, 2 * pos_near)) - pos_near;
         r.motor_velocity = int'($urandom_range(0, 2 * vel_near)) - vel_near;
      end else begin
         r.motor_position = rand_word(pos_near);
         r.motor_velocity = rand_word(vel_near);
      end
      r.new_command   = !quiet && ($urandom_range(99) < 20);
      r.command_code  = 8'($urandom);
      r.command_value = rand_word(1000);
      // terminate codes are sticky, keep them out until the last phase
      if (r.new_command && !any_code)
         case ($urandom_range(2))
            0: r.command_code = CMD_RECENTER;
            1: r.command_code = CMD_ACCEL;
            default: r.command_code = CMD_VEL;
         endcase
      return r;
   endfunction

   // present one request and hold it until it is taken
   task automatic send_tick(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full !== 1'b0)
         @(posedge clock);
   endtask

   // stop pushing and wait for every response
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [30:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] timeout, input logic [15:0] rgain,
                             input logic [15:0] igain, input logic [30:0] pos_thr,
                             input logic [30:0] vel_thr, input logic [30:0] idle_thr);
      write_reg(CSR_TIMEOUT, {15'd0, timeout});
      write_reg(CSR_RECENTER_GAIN, {15'd0, rgain});
      write_reg(CSR_IDLE_GAIN, {15'd0, igain});
      write_reg(CSR_POS_THRESH, pos_thr);
      write_reg(CSR_VEL_THRESH, vel_thr);
      write_reg(CSR_IDLE_THRESH, idle_thr);
   endtask

   // random ticks with occasional runs of no commands to trip the watchdog
   task automatic run_random(input int count, input logic any_code);
      int quiet_left;
      quiet_left = 0;
      for (int i = 0; i < count; i++) begin
         if (quiet_left == 0 && $urandom_range(24) == 0)
            quiet_left = $urandom_range(8, 40);
         send_tick(rand_tick(any_code, quiet_left != 0));
         if (quiet_left != 0)
            quiet_left--;
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // first tick after reset is spared by the watchdog, the second is not
      write_reg(CSR_TIMEOUT, 31'd0);
      send_tick(make_tick(32'd5, 32'd9, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'd5, 32'd9, 1'b0, 8'h00, 32'd0));
      drain();
      write_reg(CSR_TIMEOUT, 31'd2);

      // execute with extreme setpoints
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_ACCEL, 32'h7FFF_FFFF));
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_ACCEL, 32'h8000_0000));
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_VEL, 32'h7FFF_FFFF));
      send_tick(make_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, CMD_VEL, 32'h8000_0000));
      // ignored command fields all ones, then watchdog drops to idle
      send_tick(make_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 8'hFF, 32'hFFFF_FFFF));
      send_tick(make_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 8'hFF, 32'hFFFF_FFFF));
      send_tick(make_tick(32'd0, 32'h8000_0000, 1'b0, 8'h00, 32'd0));
      // idle damping around the stop threshold and at full scale
      send_tick(make_tick(32'd0, 32'd1310, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'd0, -32'sd1311, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'd0, 32'h7FFF_FFFF, 1'b0, 8'h00, 32'd0));
      // recenter braking, saturating both ways, then centered
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_RECENTER, 32'd0));
      send_tick(make_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'h8000_0000, 32'h8000_0000, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'd0, 32'h8000_0000, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'd163, -32'sd1637, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(-32'sd164, 32'd0, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(32'd1, 32'd1, 1'b1, CMD_VEL, 32'd7));
      drain();

      // sender idles lightly, receiver heavily
      set_config(16'd6, 16'd3840, 16'd256, 31'd164, 31'd1638, 31'd1311);
      run_random(300, 1'b0);
      drain();
      set_config(16'($urandom_range(2, 10)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 31'($urandom_range(100, 5000)),
                 31'($urandom_range(100, 5000)), 31'($urandom_range(100, 5000)));
      pos_near = 6000;
      vel_near = 6000;
      run_random(250, 1'b0);
      drain();

      // the other way round, with extreme settings
      send_idle = 72;
      recv_idle = 22;
      set_config(16'd12, 16'hFFFF, 16'd0, 31'h7FFF_FFFF, 31'd5000, 31'h7FFF_FFFF);
      pos_near = 1 << 20;
      vel_near = 8000;
      run_random(250, 1'b0);
      drain();
      set_config(16'd0, 16'd0, 16'hFFFF, 31'd0, 31'd0, 31'd0);
      pos_near = 400;
      vel_near = 3000;
      run_random(60, 1'b0);
      drain();

      // no idling from here on
      send_idle = 0;
      recv_idle = 0;
      set_config(16'd3, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 31'($urandom_range(1, 20000)), 31'($urandom_range(1, 20000)),
                 31'($urandom_range(1, 20000)));
      pos_near = 30000;
      vel_near = 30000;
      run_random(300, 1'b0);
      drain();

      // a long quiet run never trips the largest timeout
      set_config(16'hFFFF, 16'd3840, 16'd3840, 31'd164, 31'd1638, 31'd1311);
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_ACCEL, 32'd123));
      for (int i = 0; i < 300; i++)
         send_tick(make_tick($urandom, $urandom, 1'b0, 8'($urandom), $urandom));
      drain();
      // the count now exceeds a smaller timeout
      write_reg(CSR_TIMEOUT, 31'd100);
      pos_near = 400;
      vel_near = 3000;
      run_random(5, 1'b0);
      send_tick(make_tick(32'd0, 32'd900, 1'b0, 8'h00, 32'd0));
      drain();

      // termination; unused register indexes must be ignored
      set_config(TIMEOUT_RESET, GAIN_RESET, GAIN_RESET, POS_THRESH_RESET,
                 VEL_THRESH_RESET, IDLE_THRESH_RESET);
      write_reg(3'd6, 31'($urandom));
      write_reg(3'd7, 31'($urandom));
      case ($urandom_range(3))
         0: term_code = -8'sd1;
         1: term_code = 8'sh80;
         2: term_code = 8'sh7F;
         default: term_code = 8'($urandom_range(3, 126));
      endcase
      send_tick(make_tick(32'd0, 32'd0, 1'b1, term_code, 32'd0));
      send_tick(make_tick(32'h7FFF_FFFF, 32'd0, 1'b0, 8'h00, 32'd0));
      send_tick(make_tick(-32'sd1000, 32'd500, 1'b1, CMD_ACCEL, 32'd77));
      run_random(30, 1'b1);
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_VEL, 32'd5));
      // stopped holds whatever arrives
      run_random(40, 1'b1);
      send_tick(make_tick(32'd0, 32'd0, 1'b1, CMD_ACCEL, 32'd99));
      drain();

      repeat (10) @(negedge clock);
      if (failures == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
